/* src/omcs_pkg.sv */
// Shared types, codes and constants of the monotonic counter store.
package omcs_pkg;

	localparam int unsigned MAX_SLOTS_DEFAULT = 32;
	localparam int unsigned NUM_CTRS = 2;
	localparam logic [15:0] ERASED = 16'hFFFF;

	typedef logic [1:0] cmd_t;
	typedef logic [1:0] status_t;
	typedef logic [15:0] word_t;

	localparam cmd_t CMD_GET = 2'd0;
	localparam cmd_t CMD_SET = 2'd1;
	localparam cmd_t CMD_QUERY = 2'd2;

	localparam status_t STATUS_OK = 2'd0;
	localparam status_t STATUS_INVALID = 2'd1;
	localparam status_t STATUS_NO_ROOM = 2'd2;

	typedef logic [2:0] cfg_index_t;

	localparam cfg_index_t REG_TABLE_VALID = 3'd0;
	localparam cfg_index_t REG_COUNTER_COUNT = 3'd1;
	localparam cfg_index_t REG_FIRST_TAG = 3'd2;
	localparam cfg_index_t REG_FIRST_SLOT_COUNT = 3'd3;
	localparam cfg_index_t REG_SECOND_TAG = 3'd4;
	localparam cfg_index_t REG_SECOND_SLOT_COUNT = 3'd5;

endpackage

/* src/omcs_if.sv */
// Request and response channel interfaces of the monotonic counter store.
interface omcs_req_if import omcs_pkg::*;;
	logic valid;
	logic ready;
	cmd_t cmd;
	word_t counter_tag;
	word_t new_value;

	modport source(output valid, output cmd, output counter_tag, output new_value, input ready);
	modport sink(input valid, input cmd, input counter_tag, input new_value, output ready);
endinterface

interface omcs_rsp_if import omcs_pkg::*;;
	logic valid;
	logic ready;
	status_t status;
	word_t value;

	modport source(output valid, output status, output value, input ready);
	modport sink(input valid, input status, input value, output ready);
endinterface

/* src/otp_monotonic_counter_store_top.sv */
// Write-once monotonic counter store: two counters of MAX_SLOTS slots each in one
// synchronous memory. A get or set walks the counter's written slots one memory read a
// cycle, L = min(slot count, MAX_SLOTS, slots written so far) reads; a query, a miss
// or an unused command goes straight to the finish state without a scan. The result sits
// in an output register, so the next request is taken while it waits. Slots are filled
// strictly in order, so a fill count per counter marks which entries hold data; the
// memory needs no clearing pass after reset and erased entries are never read.
// Configuration must be written only while the block is idle; the block itself does not
// enforce it.
module otp_monotonic_counter_store_top import omcs_pkg::*; #(
	parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	omcs_req_if.sink   req,
	omcs_rsp_if.source rsp,
	input  logic       cfg_wr_en,
	input  cfg_index_t cfg_index,
	input  word_t      cfg_wdata
);

	localparam int unsigned DEPTH = NUM_CTRS * MAX_SLOTS;
	localparam int unsigned AW = $clog2(DEPTH);
	// fill counts and scan indexes must reach MAX_SLOTS itself
	localparam int unsigned FW = $clog2(MAX_SLOTS + 1);
	localparam logic [FW-1:0] MAX_F = FW'(MAX_SLOTS);
	localparam logic [AW-1:0] BASE1 = AW'(MAX_SLOTS);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	// configuration registers
	logic        table_valid_q;
	logic [1:0]  counter_count_q;
	word_t       tag_q [NUM_CTRS];
	word_t       slots_q [NUM_CTRS];

	// per-counter count of written slots
	logic [FW-1:0] fill_q [NUM_CTRS];

	// request context
	logic [1:0]    state_q;
	cmd_t          cmd_q;
	word_t         new_value_q;
	logic          sel_q;
	logic          found_q;
	logic [FW-1:0] len_q;
	logic [FW-1:0] idx_q;
	logic          rvalid_q;
	word_t         best_q;

	// response register
	logic    out_valid_q;
	status_t out_status_q;
	word_t   out_value_q;

	// slot memory, stored inverted as on the fuse array
	word_t        mem [DEPTH];
	word_t        rdata_q;
	logic         rd_en;
	logic [AW-1:0] rd_addr;
	logic         wr_en;
	logic [AW-1:0] wr_addr;
	word_t        wr_data;

	// counter lookup: first configured counter whose tag matches
	logic          hit0, hit1, found_d, sel_d;
	logic [FW-1:0] lim_d, len_d, lim_sel;
	word_t         slot_val;
	logic          out_free;
	logic          accept;
	logic          finish;
	status_t       fin_status;
	word_t         fin_value;

	function automatic logic [FW-1:0] clamp_slots(input word_t n);
		logic [FW-1:0] r;
		if (n >= 16'(MAX_SLOTS)) begin
			r = MAX_F;
		end else begin
			r = n[FW-1:0];
		end
		return r;
	endfunction

	always_comb begin
		hit0 = table_valid_q && (counter_count_q != 2'd0) && (tag_q[0] == req.counter_tag);
		hit1 = table_valid_q && counter_count_q[1] && (tag_q[1] == req.counter_tag);
		found_d = hit0 || hit1;
		sel_d = !hit0;
		lim_d = clamp_slots(slots_q[sel_d]);
		len_d = (lim_d < fill_q[sel_d]) ? lim_d : fill_q[sel_d];
	end

	assign accept = req.valid && (state_q == S_IDLE);
	assign req.ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || rsp.ready;
	assign finish = (state_q == S_FINISH) && out_free;

	// scan reads: one slot a cycle, data back the next cycle
	assign rd_en = (state_q == S_SCAN) && (idx_q < len_q);
	assign rd_addr = AW'(idx_q) + (sel_q ? BASE1 : '0);
	assign slot_val = ~rdata_q;

	// outcome of the request, from the scan result
	always_comb begin
		lim_sel = clamp_slots(slots_q[sel_q]);
		fin_status = STATUS_INVALID;
		fin_value = '0;
		wr_en = 1'b0;
		wr_addr = AW'(fill_q[sel_q]) + (sel_q ? BASE1 : '0);
		wr_data = ~new_value_q;
		if (found_q) begin
			unique case (cmd_q)
				CMD_GET: begin
					fin_status = STATUS_OK;
					fin_value = best_q;
				end
				CMD_SET: begin
					priority if (new_value_q <= best_q) begin
						fin_status = STATUS_INVALID;
					end else if (fill_q[sel_q] >= lim_sel) begin
						fin_status = STATUS_NO_ROOM;
					end else begin
						fin_status = STATUS_OK;
						wr_en = finish;
					end
				end
				CMD_QUERY: begin
					if (slots_q[sel_q] != ERASED) begin
						fin_status = STATUS_OK;
						fin_value = slots_q[sel_q];
					end
				end
				default: begin
					fin_status = STATUS_INVALID;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// configuration writes; indexes past the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_valid_q <= 1'b0;
			counter_count_q <= '0;
			for (int i = 0; i < NUM_CTRS; i++) begin
				tag_q[i] <= '0;
				slots_q[i] <= '0;
			end
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_TABLE_VALID: table_valid_q <= cfg_wdata[0];
				REG_COUNTER_COUNT: counter_count_q <= cfg_wdata[1:0];
				REG_FIRST_TAG: tag_q[0] <= cfg_wdata;
				REG_FIRST_SLOT_COUNT: slots_q[0] <= cfg_wdata;
				REG_SECOND_TAG: tag_q[1] <= cfg_wdata;
				REG_SECOND_SLOT_COUNT: slots_q[1] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rvalid_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CTRS; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			rvalid_q <= rd_en;
			// a new result may replace one leaving in the same cycle
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (found_d && (req.cmd == CMD_GET || req.cmd == CMD_SET))
							? S_SCAN : S_FINISH;
					end
				end
				S_SCAN: begin
					// last read data is folded in at this same edge
					if (idx_q == len_q) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (wr_en) begin
							fill_q[sel_q] <= fill_q[sel_q] + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request context and response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.cmd;
			new_value_q <= req.new_value;
			sel_q <= sel_d;
			found_q <= found_d;
			len_q <= len_d;
			idx_q <= '0;
			best_q <= '0;
		end else begin
			if (rd_en) begin
				idx_q <= idx_q + 1'b1;
			end
			if (rvalid_q && (slot_val > best_q)) begin
				best_q <= slot_val;
			end
		end
		if (finish) begin
			out_status_q <= fin_status;
			out_value_q <= fin_value;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.value = out_value_q;

endmodule

/* dv/tb.sv */
// Self-checking testbench for the write-once monotonic counter store.
`timescale 1ns / 1ps

module tb;
	import omcs_pkg::*;

	localparam int unsigned SLOTS = MAX_SLOTS_DEFAULT;
	localparam cmd_t CMD_UNUSED = 2'd3;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 85;

	// Per-phase register settings for the random part. A slot count of 0 in
	// phase 8 of the first counter is replaced by a random 16-bit count.
	localparam int PH_VALID [PHASES] = '{1, 1, 1, 1, 0, 1, 1, 1, 1, 1};
	localparam int PH_COUNT [PHASES] = '{2, 2, 1, 3, 2, 0, 2, 2, 1, 2};
	localparam int PH_SLOTS0 [PHASES] = '{4, 8, 0, 16, 24, 32, 'hFFFF, 40, 0, 'hFFFF};
	localparam int PH_SLOTS1 [PHASES] = '{3, 6, 12, 20, 'hFFFE, 'hFFFF, 32, 1, 0, 33};

	typedef struct packed {
		status_t status;
		word_t   value;
	} counter_rsp_t;

	// A pinned result is typed into the directed table; otherwise the
	// predictor supplies the expectation at request transfer.
	typedef struct packed {
		logic         pinned;
		counter_rsp_t rsp;
	} pin_t;

	typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

	typedef struct {
		row_kind_t    kind;
		cfg_index_t   reg_idx;
		word_t        reg_data;
		cmd_t         op;
		word_t        tag;
		word_t        nv;
		logic         pinned;
		counter_rsp_t rsp;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	cfg_index_t cfg_index;
	word_t      cfg_wdata;

	omcs_req_if req_ch();
	omcs_rsp_if rsp_ch();

	otp_monotonic_counter_store_top #(.MAX_SLOTS(SLOTS)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Shadow of the block: slot memory (inverted values) and register copies.
	word_t        slot_mem [2*SLOTS];
	logic         tbl_on;
	logic [1:0]   ctr_num;
	word_t        ctr_tag [2];
	word_t        ctr_slots [2];

	counter_rsp_t expected_rsp_q [$];
	pin_t         pin_q [$];
	dir_row_t     dir_rows [$];
	int           err_cnt;
	logic         src_burst;
	logic         allow_max;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Generous fixed limit, several times what the slowest correct run needs.
	initial begin
		#1000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// First configured counter with a matching tag, or -1.
	function automatic int find_counter(word_t tag);
		int n;
		int hit;
		n = (ctr_num > 2'd2) ? 2 : int'(ctr_num);
		hit = -1;
		if (tbl_on)
			for (int i = 0; i < n; i++)
				if (hit < 0 && ctr_tag[i] == tag)
					hit = i;
		return hit;
	endfunction

	// Walks the counter's slots up to the first free one; scan is clamped to SLOTS.
	function automatic word_t counter_high(int idx, output int free_at);
		int    n;
		word_t v;
		word_t best;
		logic  seen_free;
		n = (ctr_slots[idx] > SLOTS) ? SLOTS : int'(ctr_slots[idx]);
		best = '0;
		free_at = -1;
		seen_free = 1'b0;
		for (int i = 0; i < n; i++)
			if (!seen_free) begin
				v = ~slot_mem[idx*SLOTS + i];
				if (v == '0) begin
					seen_free = 1'b1;
					free_at = idx*SLOTS + i;
				end else if (v > best) begin
					best = v;
				end
			end
		return best;
	endfunction

	// Result of one request; a successful set updates the shadow memory.
	function automatic counter_rsp_t predict_counter_rsp(cmd_t op, word_t tag, word_t nv);
		counter_rsp_t r;
		int           idx;
		int           free_at;
		word_t        best;
		r.status = STATUS_INVALID;
		r.value = '0;
		idx = find_counter(tag);
		if (idx >= 0) begin
			best = counter_high(idx, free_at);
			case (op)
				CMD_GET: begin
					r.status = STATUS_OK;
					r.value = best;
				end
				CMD_SET: begin
					if (nv <= best)
						r.status = STATUS_INVALID;
					else if (free_at < 0)
						r.status = STATUS_NO_ROOM;
					else begin
						slot_mem[free_at] = ~nv;
						r.status = STATUS_OK;
					end
				end
				CMD_QUERY: begin
					if (ctr_slots[idx] != ERASED) begin
						r.status = STATUS_OK;
						r.value = ctr_slots[idx];
					end
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	function automatic void cfg_row(cfg_index_t idx, word_t data);
		dir_row_t row;
		row = '{ROW_CFG, idx, data, CMD_GET, '0, '0, 1'b0, '0};
		dir_rows.push_back(row);
	endfunction

	function automatic void req_row(cmd_t op, word_t tag, word_t nv, logic pinned,
			status_t st, word_t val);
		dir_row_t row;
		row = '{ROW_REQ, REG_TABLE_VALID, '0, op, tag, nv, pinned, '{st, val}};
		dir_rows.push_back(row);
	endfunction

	// Request transfer: work out the expectation in acceptance order.
	always @(posedge clk) begin
		pin_t pin;
		counter_rsp_t pred;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			pred = predict_counter_rsp(req_ch.cmd, req_ch.counter_tag, req_ch.new_value);
			pin = pin_q.pop_front();
			expected_rsp_q.push_back(pin.pinned ? pin.rsp : pred);
		end
	end

	// Response transfer: compare against the oldest expectation.
	always @(posedge clk) begin
		counter_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsp_q.size() == 0) begin
				$error("unexpected response: status %0d value 0x%04h",
					rsp_ch.status, rsp_ch.value);
				err_cnt++;
			end else begin
				want = expected_rsp_q.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status mismatch: expected %0d, got %0d",
						want.status, rsp_ch.status);
					err_cnt++;
				end
				if (rsp_ch.value !== want.value) begin
					$error("value mismatch: expected 0x%04h, got 0x%04h",
						want.value, rsp_ch.value);
					err_cnt++;
				end
			end
		end
	end

	// Response side: random stall per transfer, burst stretches, and one long
	// hold-off so the output register fills and request ready drops.
	initial begin
		int   gap;
		int   xfers;
		logic snk_burst;
		rsp_ch.ready = 1'b0;
		xfers = 0;
		snk_burst = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (xfers % 50 == 0)
				snk_burst = ($urandom_range(0, 2) == 0);
			if (xfers == 60)
				gap = 300;
			else
				gap = snk_burst ? 0 : $urandom_range(0, 15);
			if (gap != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			xfers++;
		end
	end

	// Offer one request and hold it until the transfer.
	task automatic send_req(cmd_t op, word_t tag, word_t nv, logic pinned, counter_rsp_t rsp);
		int gap;
		gap = src_burst ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pin_q.push_back('{pinned, rsp});
		req_ch.valid <= 1'b1;
		req_ch.cmd <= op;
		req_ch.counter_tag <= tag;
		req_ch.new_value <= nv;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// Drain everything in flight before touching the registers.
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (expected_rsp_q.size() != 0 || pin_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_index_t idx, word_t data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_TABLE_VALID:       tbl_on = data[0];
			REG_COUNTER_COUNT:     ctr_num = data[1:0];
			REG_FIRST_TAG:         ctr_tag[0] = data;
			REG_FIRST_SLOT_COUNT:  ctr_slots[0] = data;
			REG_SECOND_TAG:        ctr_tag[1] = data;
			REG_SECOND_SLOT_COUNT: ctr_slots[1] = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Random request, mostly aimed at configured tags with increasing set values.
	task automatic send_random();
		int    pick;
		int    idx;
		int    free_at;
		int    cand;
		cmd_t  op;
		word_t tag;
		word_t nv;
		word_t best;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			tag = ctr_tag[0];
		else if (pick < 90)
			tag = ctr_tag[1];
		else
			tag = word_t'($urandom_range(0, 16'hFFFF));
		pick = $urandom_range(0, 99);
		if (pick < 35)
			op = CMD_GET;
		else if (pick < 80)
			op = CMD_SET;
		else if (pick < 93)
			op = CMD_QUERY;
		else
			op = CMD_UNUSED;
		idx = find_counter(tag);
		best = (idx >= 0) ? counter_high(idx, free_at) : '0;
		pick = $urandom_range(0, 99);
		if (op != CMD_SET || pick >= 85) begin
			nv = word_t'($urandom_range(0, 16'hFFFF));
		end else if (allow_max && pick < 10) begin
			nv = 16'hFFFF;
		end else if (pick < 70) begin
			cand = int'(best) + $urandom_range(1, 1500);
			if (cand > 'hFFFE)
				cand = allow_max ? 'hFFFF : 'hFFFE;
			nv = word_t'(cand);
		end else begin
			nv = word_t'($urandom_range(0, int'(best)));
		end
		send_req(op, tag, nv, 1'b0, '0);
	endtask

	initial begin
		dir_row_t row;
		row_kind_t prev_kind;
		word_t s0;
		word_t t0;
		word_t t1;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_TABLE_VALID;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_GET;
		req_ch.counter_tag = '0;
		req_ch.new_value = '0;
		err_cnt = 0;
		src_burst = 1'b0;
		allow_max = 1'b0;
		tbl_on = 1'b0;
		ctr_num = '0;
		for (int i = 0; i < 2; i++) begin
			ctr_tag[i] = '0;
			ctr_slots[i] = '0;
		end
		for (int i = 0; i < 2*SLOTS; i++)
			slot_mem[i] = ERASED;

		// Directed table. After reset nothing is provisioned, so every command misses.
		req_row(CMD_GET, 16'h0000, 16'h0000, 1'b1, STATUS_INVALID, 16'h0000);
		req_row(CMD_QUERY, 16'h0000, 16'hFFFF, 1'b1, STATUS_INVALID, 16'h0000);
		cfg_row(REG_COUNTER_COUNT, 16'd2);
		cfg_row(REG_FIRST_TAG, 16'h1234);
		cfg_row(REG_FIRST_SLOT_COUNT, 16'h0000);
		cfg_row(REG_SECOND_TAG, 16'hFFFF);
		cfg_row(REG_SECOND_SLOT_COUNT, 16'hFFFF);
		// Collection not marked present yet
		req_row(CMD_QUERY, 16'h1234, 16'h0000, 1'b1, STATUS_INVALID, 16'h0000);
		cfg_row(REG_TABLE_VALID, 16'd1);
		// Zero slots: query answers 0, get scans nothing, set has no room
		req_row(CMD_QUERY, 16'h1234, 16'h0000, 1'b1, STATUS_OK, 16'h0000);
		req_row(CMD_GET, 16'h1234, 16'h0000, 1'b1, STATUS_OK, 16'h0000);
		req_row(CMD_SET, 16'h1234, 16'hFFFF, 1'b1, STATUS_NO_ROOM, 16'h0000);
		// Unprovisioned count: query invalid, scans still clamp to the slot row
		req_row(CMD_QUERY, 16'hFFFF, 16'h0000, 1'b1, STATUS_INVALID, 16'h0000);
		req_row(CMD_GET, 16'hFFFF, 16'h0000, 1'b1, STATUS_OK, 16'h0000);
		req_row(CMD_SET, 16'hFFFF, 16'h0000, 1'b1, STATUS_INVALID, 16'h0000);
		req_row(CMD_SET, 16'hFFFF, 16'h0001, 1'b1, STATUS_OK, 16'h0000);
		req_row(CMD_GET, 16'hFFFF, 16'h0000, 1'b1, STATUS_OK, 16'h0001);
		req_row(CMD_SET, 16'hFFFF, 16'h0001, 1'b1, STATUS_INVALID, 16'h0000);
		req_row(CMD_UNUSED, 16'hFFFF, 16'h5A5A, 1'b1, STATUS_INVALID, 16'h0000);
		req_row(CMD_QUERY, 16'h5555, 16'h0000, 1'b1, STATUS_INVALID, 16'h0000);
		// Duplicate tags: counter zero must win; fill its two slots
		cfg_row(REG_FIRST_SLOT_COUNT, 16'd2);
		cfg_row(REG_SECOND_TAG, 16'h1234);
		req_row(CMD_SET, 16'h1234, 16'h8000, 1'b0, STATUS_OK, 16'h0000);
		req_row(CMD_SET, 16'h1234, 16'h8001, 1'b0, STATUS_OK, 16'h0000);
		req_row(CMD_SET, 16'h1234, 16'h9000, 1'b1, STATUS_NO_ROOM, 16'h0000);
		req_row(CMD_GET, 16'h1234, 16'h0000, 1'b0, STATUS_OK, 16'h0000);
		req_row(CMD_QUERY, 16'h1234, 16'h0000, 1'b1, STATUS_OK, 16'h0002);
		// Count 3 behaves as 2; counter one is now the only 0x1234
		cfg_row(REG_COUNTER_COUNT, 16'd3);
		cfg_row(REG_FIRST_TAG, 16'hABCD);
		cfg_row(REG_SECOND_SLOT_COUNT, 16'hFFFE);
		req_row(CMD_GET, 16'h1234, 16'h0000, 1'b0, STATUS_OK, 16'h0000);
		req_row(CMD_QUERY, 16'h1234, 16'h0000, 1'b1, STATUS_OK, 16'hFFFE);
		cfg_row(REG_COUNTER_COUNT, 16'd0);
		req_row(CMD_GET, 16'hABCD, 16'h0000, 1'b1, STATUS_INVALID, 16'h0000);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		prev_kind = ROW_REQ;
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.kind == ROW_CFG) begin
				if (prev_kind != ROW_CFG)
					wait_idle();
				cfg_write(row.reg_idx, row.reg_data);
			end else begin
				send_req(row.op, row.tag, row.nv, row.pinned, row.rsp);
			end
			prev_kind = row.kind;
		end

		// Random phases: every register rewritten each phase, slot counts
		// varying by phase, often larger so fresh slots open as the earlier ones fill.
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			t0 = word_t'($urandom_range(0, 16'hFFFF));
			t1 = word_t'($urandom_range(0, 16'hFFFF));
			if (p == 2)
				t1 = t0;
			if (p == 6) begin
				t0 = 16'h0000;
				t1 = 16'hFFFF;
			end
			s0 = (p == 8) ? word_t'($urandom_range(0, 16'hFFFF)) : word_t'(PH_SLOTS0[p]);
			cfg_write(REG_TABLE_VALID, word_t'(PH_VALID[p]));
			cfg_write(REG_COUNTER_COUNT, word_t'(PH_COUNT[p]));
			cfg_write(REG_FIRST_TAG, t0);
			cfg_write(REG_FIRST_SLOT_COUNT, s0);
			cfg_write(REG_SECOND_TAG, t1);
			cfg_write(REG_SECOND_SLOT_COUNT, word_t'(PH_SLOTS1[p]));
			src_burst = ($urandom_range(0, 3) == 0);
			allow_max = (p == PHASES - 1);
			for (int k = 0; k < ITEMS_PER_PHASE; k++)
				send_random();
		end

		wait_idle();
		repeat (40) @(posedge clk);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
